@@ design/clre_pkg.sv @@
// Package for the code length run encoder: beat widths, symbol codes,
// the result entry type and the run coding helper functions. No dependencies.
package clre_pkg;

    // beat widths
    localparam int LenW      = 4;
    localparam int SymW      = 5;
    localparam int ExtValW   = 7;
    localparam int ExtCntW   = 3;
    localparam int CountW    = 8;
    localparam int InDataW   = 8;
    localparam int OutDataW  = 16;
    localparam int MaxResults = 5;
    localparam int IdxW      = $clog2(MaxResults);

    // symbol codes
    localparam logic [SymW-1:0] SymRepeat  = 5'd16;
    localparam logic [SymW-1:0] SymZeros3  = 5'd17;
    localparam logic [SymW-1:0] SymZeros11 = 5'd18;

    // run limits
    localparam logic [CountW-1:0] ZeroRunMax  = 8'd138;
    localparam logic [CountW-1:0] LongZeroMin = 8'd11;
    localparam logic [CountW-1:0] ShortZeroMin = 8'd3;
    localparam logic [CountW-1:0] RepeatGroup = 8'd6;
    localparam logic [CountW-1:0] RepeatMin   = 8'd3;
    localparam logic [ExtValW-1:0] RepeatSixVal = 7'd3;
    localparam logic [ExtValW-1:0] LongZeroFull = 7'd127;

    // extra bit counts
    localparam logic [ExtCntW-1:0] ExtBitsRepeat = 3'd2;
    localparam logic [ExtCntW-1:0] ExtBitsZeros3 = 3'd3;
    localparam logic [ExtCntW-1:0] ExtBitsZeros11 = 3'd7;

    typedef struct packed {
        logic               last_symbol;
        logic [ExtCntW-1:0] extra_count;
        logic [ExtValW-1:0] extra_value;
        logic [SymW-1:0]    symbol;
    } res_t;

    typedef struct packed {
        logic [IdxW-1:0]            n;
        res_t [MaxResults-1:0]      r;
    } res_list_t;

    // append one symbol to the list
    function automatic res_list_t list_put(
        input res_list_t           lst,
        input logic [SymW-1:0]     sym,
        input logic [ExtValW-1:0]  val
    );
        res_list_t          o;
        logic [ExtCntW-1:0] bits;
        o    = lst;
        bits = '0;
        if (sym == SymRepeat) begin
            bits = ExtBitsRepeat;
        end else if (sym == SymZeros3) begin
            bits = ExtBitsZeros3;
        end else if (sym == SymZeros11) begin
            bits = ExtBitsZeros11;
        end
        if (o.n < IdxW'(MaxResults)) begin
            o.r[o.n].symbol      = sym;
            o.r[o.n].extra_value = val;
            o.r[o.n].extra_count = bits;
            o.r[o.n].last_symbol = 1'b0;
            o.n                  = o.n + IdxW'(1);
        end
        return o;
    endfunction

    // close an open run and append its pending symbols
    function automatic res_list_t list_flush(
        input res_list_t          lst,
        input logic               started,
        input logic [LenW-1:0]    value,
        input logic [CountW-1:0]  count
    );
        res_list_t         o;
        logic [CountW-1:0] c;
        logic [CountW-1:0] d;
        o = lst;
        c = count;
        if (started) begin
            if (value == '0) begin
                if (c >= LongZeroMin) begin
                    d = c - LongZeroMin;
                    o = list_put(o, SymZeros11, d[ExtValW-1:0]);
                end else if (c >= ShortZeroMin) begin
                    d = c - ShortZeroMin;
                    o = list_put(o, SymZeros3, d[ExtValW-1:0]);
                end else begin
                    for (int i = 0; i < 2; i++) begin
                        if (CountW'(i) < c) begin
                            o = list_put(o, '0, '0);
                        end
                    end
                end
            end else begin
                if (c >= RepeatMin) begin
                    o = list_put(o, SymRepeat, '0);
                    c = c - RepeatMin;
                end
                for (int i = 0; i < 2; i++) begin
                    if (CountW'(i) < c) begin
                        o = list_put(o, SymW'(value), '0);
                    end
                end
            end
        end
        return o;
    endfunction

endpackage

@@ design/code_length_run_encoder_unit.sv @@
// Code length run encoder: turns a stream of code lengths into run coded
// header symbols (literals, 16, 17, 18 with extra bits). Uses clre_pkg.
//
// Usage:
//   s_axis carries one code length per beat; tlast marks the final length
//   of a table, which flushes the open run. m_axis carries one symbol per
//   beat with its extra bits value and count; tlast marks the final symbol
//   of a table.
//   An accepted length is registered, then coded into a group of zero to
//   four symbols, which is unloaded one symbol per cycle, while the receiver
//   accepts, into the output register. The first symbol of a length passes
//   through the input register, the symbol group and the output register.
//   Throughput: one length per cycle while each length yields at most one
//   symbol and the receiver accepts; a length that yields several symbols
//   holds the input until its group is unloaded through the single symbol per cycle output register.
//   A length that continues a run often yields no symbol at all.
//   When the receiver stalls, the output beat holds, the symbol group
//   waits, and s_axis_tready drops once the input register is full.
//   Reset (rst_n low) empties all stages and closes any open run.
module code_length_run_encoder_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [clre_pkg::InDataW-1:0]  s_axis_tdata,   // [3:0] code_length, [7:4] zero
    input  logic                          s_axis_tlast,   // last_length
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [clre_pkg::OutDataW-1:0] m_axis_tdata,   // [4:0] symbol, [11:5] extra_value,
                                                          // [14:12] extra_count, [15] zero
    output logic                          m_axis_tlast    // last_symbol
);
    import clre_pkg::*;

    // input register
    logic            in_valid_reg;
    logic [LenW-1:0] in_len_reg;
    logic            in_last_reg;

    // run state
    logic              run_started_reg, run_started_next;
    logic [LenW-1:0]   run_value_reg, run_value_next;
    logic [CountW-1:0] run_count_reg, run_count_next;

    // symbol group
    logic            grp_valid_reg;
    logic [IdxW-1:0] grp_idx_reg;
    res_list_t       grp_reg;
    res_list_t       grp_next;

    // output register
    logic out_valid_reg;
    res_t out_reg;

    logic              grp_take;
    logic              grp_done;
    logic              grp_free;
    logic              adv;
    logic [CountW-1:0] cnt_inc;

    // handshake between stages
    assign grp_take      = grp_valid_reg && (!out_valid_reg || m_axis_tready);
    assign grp_done      = grp_take && (grp_idx_reg == grp_reg.n - IdxW'(1));
    assign grp_free      = !grp_valid_reg || grp_done;
    assign adv           = in_valid_reg && grp_free;
    assign s_axis_tready = !in_valid_reg || adv;
    assign cnt_inc       = run_count_reg + CountW'(1);

    // code one length against the open run
    always_comb
    begin
        res_list_t lst;
        lst              = '0;
        run_started_next = run_started_reg;
        run_value_next   = run_value_reg;
        run_count_next   = run_count_reg;
        if (run_started_reg && (in_len_reg == run_value_reg)) begin
            if (in_len_reg == '0) begin
                if (cnt_inc >= ZeroRunMax) begin
                    lst              = list_put(lst, SymZeros11, LongZeroFull);
                    run_started_next = 1'b0;
                    run_count_next   = '0;
                end else begin
                    run_count_next = cnt_inc;
                end
            end else if (cnt_inc >= RepeatGroup) begin
                lst            = list_put(lst, SymRepeat, RepeatSixVal);
                run_count_next = '0;
            end else begin
                run_count_next = cnt_inc;
            end
        end else begin
            lst              = list_flush(lst, run_started_reg, run_value_reg, run_count_reg);
            run_started_next = 1'b1;
            run_value_next   = in_len_reg;
            if (in_len_reg == '0) begin
                run_count_next = CountW'(1);
            end else begin
                lst            = list_put(lst, SymW'(in_len_reg), '0);
                run_count_next = '0;
            end
        end
        // end of table closes the run
        if (in_last_reg) begin
            lst = list_flush(lst, run_started_next, run_value_next, run_count_next);
            run_started_next = 1'b0;
            run_count_next   = '0;
            if (lst.n != '0) begin
                lst.r[lst.n - IdxW'(1)].last_symbol = 1'b1;
            end
        end
        grp_next = lst;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg    <= 1'b0;
            run_started_reg <= 1'b0;
            run_value_reg   <= '0;
            run_count_reg   <= '0;
            grp_valid_reg   <= 1'b0;
            grp_idx_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (adv) begin
                run_started_reg <= run_started_next;
                run_value_reg   <= run_value_next;
                run_count_reg   <= run_count_next;
            end
            if (adv && (grp_next.n != '0)) begin
                grp_valid_reg <= 1'b1;
                grp_idx_reg   <= '0;
            end else if (grp_done) begin
                grp_valid_reg <= 1'b0;
            end else if (grp_take) begin
                grp_idx_reg <= grp_idx_reg + IdxW'(1);
            end
            if (grp_take) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_len_reg  <= s_axis_tdata[LenW-1:0];
            in_last_reg <= s_axis_tlast;
        end
        if (adv && (grp_next.n != '0)) begin
            grp_reg <= grp_next;
        end
        if (grp_take) begin
            out_reg <= grp_reg.r[grp_idx_reg];
        end
    end

    // output beat
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg.extra_count, out_reg.extra_value, out_reg.symbol};
    assign m_axis_tlast  = out_reg.last_symbol;

endmodule
